FILE: rtl/oah_pkg.sv
package oah_pkg;

  localparam int KEY_W      = 16;
  localparam int STATUS_W   = 2;
  localparam int SLOT_W     = 5;
  localparam int SIZE_W     = 6;
  localparam int MODE_W     = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  localparam int TABLE_DEPTH_DEF = 32;

  localparam logic [SIZE_W-1:0] TABLE_SIZE_RST = 6'd16;
  localparam logic [MODE_W-1:0] PROBE_MODE_RST = 2'd0;

  typedef logic [KEY_W-1:0]      key_t;
  typedef logic [SLOT_W-1:0]     slot_t;
  typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;
  typedef logic [CFG_DATA_W-1:0] cfg_data_t;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_HOME  = 2'd0,
    STATUS_MOVED = 2'd1,
    STATUS_FULL  = 2'd2
  } status_t;

  localparam cfg_idx_t REG_TABLE_SIZE = 2'd0;
  localparam cfg_idx_t REG_PROBE_MODE = 2'd1;

  localparam logic [MODE_W-1:0] MODE_LINEAR = 2'd0;
  localparam logic [MODE_W-1:0] MODE_QUAD   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_HASH2  = 2'd2;

endpackage

FILE: rtl/oah_in_if.sv
interface oah_in_if;
  import oah_pkg::*;

  logic valid;
  logic ready;
  key_t key;

  modport source (output valid, output key, input ready);
  modport sink   (input valid, input key, output ready);
endinterface

FILE: rtl/oah_out_if.sv
interface oah_out_if;
  import oah_pkg::*;

  logic    valid;
  logic    ready;
  status_t status;
  slot_t   slot;

  modport source (output valid, output status, output slot, input ready);
  modport sink   (input valid, input status, input slot, output ready);
endinterface

FILE: rtl/oah_cfg_if.sv
interface oah_cfg_if;
  import oah_pkg::*;

  logic      valid;
  logic      ready;
  cfg_idx_t  index;
  cfg_data_t data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: rtl/open_addressing_hash_insert_core.sv
// open-addressed hash table insert engine
//
// in_ch carries one key per transaction; out_ch returns one transaction per
// key with a status (placed at home, placed after collision, table full)
// and the slot used (home slot when full). cfg_ch writes table_size
// (index 0) and probe_mode (index 1); it is always ready and is meant to be
// written only while no key is in flight.
//
// one key at a time: the key is taken, its home slot is found by a 16-step
// bit-serial remainder, then the probe loop checks one slot per pass.
// steps: load, remainder, home, test home; on a collision the advance,
// quad position, test wrap and test slot steps repeat until a free slot
// is found or the home slot comes round again (table full); then put. the
// next key is taken in the cycle after the result is written, so no new key
// is taken while one is in flight; the order is set by the microcode program.
//
// reset (synchronous, active low) empties every slot, restores size 16 and
// linear probing, and drops any pending result. a stalled receiver holds
// the result in the output register; the next key is still worked on and
// waits at its final step until the register frees.
module open_addressing_hash_insert_core #(
  parameter int TABLE_DEPTH = oah_pkg::TABLE_DEPTH_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  oah_in_if.sink         in_ch,
  oah_out_if.source      out_ch,
  oah_cfg_if.sink        cfg_ch
);
  import oah_pkg::*;

  // only slots below the largest reachable size ever hold a key
  localparam int MAX_SIZE   = (1 << SIZE_W) - 1;
  localparam int USED_DEPTH = (TABLE_DEPTH < MAX_SIZE + 1) ? TABLE_DEPTH : MAX_SIZE + 1;
  localparam int IDX_W      = $clog2(USED_DEPTH);
  localparam int CNT_W      = $clog2(KEY_W);

  typedef logic [3:0]        step_t;
  typedef logic [SIZE_W-1:0] size_t;

  // micro-operations applied to the datapath
  typedef enum logic [3:0] {
    OP_NOP,
    OP_LOAD,
    OP_DIV,
    OP_HOME,
    OP_ADV,
    OP_QPOS,
    OP_PUT_HOME,
    OP_PUT_MOVED,
    OP_PUT_FULL
  } uop_t;

  // branch conditions
  typedef enum logic [2:0] {
    C_NEVER,
    C_WAIT_IN,
    C_DIV_MORE,
    C_HOME_FREE,
    C_AT_HOME,
    C_SLOT_USED,
    C_OUT_BUSY
  } cond_t;

  typedef struct packed {
    uop_t  op;
    cond_t cond;
    step_t jmp;
    step_t nxt;
  } uword_t;

  // program steps
  localparam step_t S_IDLE      = 4'd0;
  localparam step_t S_DIV       = 4'd1;
  localparam step_t S_HOME      = 4'd2;
  localparam step_t S_TEST_HOME = 4'd3;
  localparam step_t S_ADV       = 4'd4;
  localparam step_t S_QPOS      = 4'd5;
  localparam step_t S_TEST_WRAP = 4'd6;
  localparam step_t S_TEST_SLOT = 4'd7;
  localparam step_t S_PUT_HOME  = 4'd8;
  localparam step_t S_PUT_MOVED = 4'd9;
  localparam step_t S_PUT_FULL  = 4'd10;

  // control store: branch to jmp when cond holds, else go to nxt
  function automatic uword_t urom(input step_t pc);
    uword_t w;
    unique case (pc)
      S_IDLE:      w = '{OP_LOAD,      C_WAIT_IN,   S_IDLE,      S_DIV};
      S_DIV:       w = '{OP_DIV,       C_DIV_MORE,  S_DIV,       S_HOME};
      S_HOME:      w = '{OP_HOME,      C_NEVER,     S_IDLE,      S_TEST_HOME};
      S_TEST_HOME: w = '{OP_NOP,       C_HOME_FREE, S_PUT_HOME,  S_ADV};
      S_ADV:       w = '{OP_ADV,       C_NEVER,     S_IDLE,      S_QPOS};
      S_QPOS:      w = '{OP_QPOS,      C_NEVER,     S_IDLE,      S_TEST_WRAP};
      S_TEST_WRAP: w = '{OP_NOP,       C_AT_HOME,   S_PUT_FULL,  S_TEST_SLOT};
      S_TEST_SLOT: w = '{OP_NOP,       C_SLOT_USED, S_ADV,       S_PUT_MOVED};
      S_PUT_HOME:  w = '{OP_PUT_HOME,  C_OUT_BUSY,  S_PUT_HOME,  S_IDLE};
      S_PUT_MOVED: w = '{OP_PUT_MOVED, C_OUT_BUSY,  S_PUT_MOVED, S_IDLE};
      S_PUT_FULL:  w = '{OP_PUT_FULL,  C_OUT_BUSY,  S_PUT_FULL,  S_IDLE};
      default:     w = '{OP_NOP,       C_NEVER,     S_IDLE,      S_IDLE};
    endcase
    return w;
  endfunction

  // (a + b) mod n for a + b < 2n
  function automatic size_t mod_add(input size_t a, input size_t b, input size_t n);
    logic [SIZE_W:0] t;
    t = {1'b0, a} + {1'b0, b};
    return (t >= {1'b0, n}) ? SIZE_W'(t - {1'b0, n}) : t[SIZE_W-1:0];
  endfunction

  // control state
  step_t                 pc_r, pc_nxt;
  logic                  out_valid_r;
  logic [USED_DEPTH-1:0] used_r;
  size_t                 tsize_r;
  logic [MODE_W-1:0]     mode_r;

  // datapath
  key_t                  key_r;
  size_t                 rem_r;
  logic [CNT_W-1:0]      cnt_r;
  size_t                 n_r;
  logic                  quad_r;
  size_t                 home_r;
  size_t                 s_r;
  size_t                 sq_r;   // i*i mod n
  size_t                 d_r;    // (2i+1) mod n
  status_t               status_r;
  slot_t                 slot_r;

  uword_t                uw;
  logic                  cond_hit;
  logic                  out_busy;
  logic                  put_fire;
  size_t                 n_act;
  logic [SIZE_W:0]       div_trial;
  size_t                 div_rem;

  assign uw       = urom(pc_r);
  assign out_busy = out_valid_r && !out_ch.ready;
  assign put_fire = (uw.op == OP_PUT_HOME || uw.op == OP_PUT_MOVED ||
                     uw.op == OP_PUT_FULL) && !out_busy;

  // clamp the configured size to 1..TABLE_DEPTH
  always_comb begin
    if (tsize_r == '0) begin
      n_act = size_t'(1);
    end else if (int'(tsize_r) > TABLE_DEPTH) begin
      n_act = size_t'(TABLE_DEPTH);
    end else begin
      n_act = tsize_r;
    end
  end

  // one restoring remainder step: shift in the next key bit
  assign div_trial = {rem_r, key_r[KEY_W-1]};
  assign div_rem   = (div_trial >= {1'b0, n_r}) ? SIZE_W'(div_trial - {1'b0, n_r})
                                                : div_trial[SIZE_W-1:0];

  always_comb begin
    case (uw.cond)
      C_WAIT_IN:   cond_hit = !in_ch.valid;
      C_DIV_MORE:  cond_hit = (cnt_r != '0);
      C_HOME_FREE: cond_hit = !used_r[home_r[IDX_W-1:0]];
      C_AT_HOME:   cond_hit = (s_r == home_r);
      C_SLOT_USED: cond_hit = used_r[s_r[IDX_W-1:0]];
      C_OUT_BUSY:  cond_hit = out_busy;
      default:     cond_hit = 1'b0;
    endcase
    pc_nxt = cond_hit ? uw.jmp : uw.nxt;
  end

  assign in_ch.ready   = (uw.op == OP_LOAD);
  assign cfg_ch.ready  = 1'b1;
  assign out_ch.valid  = out_valid_r;
  assign out_ch.status = status_r;
  assign out_ch.slot   = slot_r;

  // sequencer, occupancy and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r        <= S_IDLE;
      out_valid_r <= 1'b0;
      used_r      <= '0;
      tsize_r     <= TABLE_SIZE_RST;
      mode_r      <= PROBE_MODE_RST;
    end else begin
      pc_r <= pc_nxt;

      if (put_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end

      if (!out_busy) begin
        if (uw.op == OP_PUT_HOME) begin
          used_r[home_r[IDX_W-1:0]] <= 1'b1;
        end else if (uw.op == OP_PUT_MOVED) begin
          used_r[s_r[IDX_W-1:0]] <= 1'b1;
        end
      end

      if (cfg_ch.valid) begin
        if (cfg_ch.index == REG_TABLE_SIZE) begin
          tsize_r <= cfg_ch.data[SIZE_W-1:0];
        end else if (cfg_ch.index == REG_PROBE_MODE) begin
          mode_r <= cfg_ch.data[MODE_W-1:0];
        end
      end
    end
  end

  // datapath driven by the current control word
  always_ff @(posedge clk) begin
    case (uw.op)
      OP_LOAD: begin
        if (in_ch.valid) begin
          key_r  <= in_ch.key;
          rem_r  <= '0;
          cnt_r  <= CNT_W'(KEY_W - 1);
          n_r    <= n_act;
          quad_r <= (mode_r == MODE_QUAD);
        end
      end
      OP_DIV: begin
        rem_r <= div_rem;
        key_r <= {key_r[KEY_W-2:0], 1'b0};
        cnt_r <= cnt_r - CNT_W'(1);
      end
      OP_HOME: begin
        home_r <= rem_r;
        s_r    <= rem_r;
        sq_r   <= '0;
        d_r    <= (n_r == size_t'(1)) ? '0 : size_t'(1);
      end
      OP_ADV: begin
        if (quad_r) begin
          sq_r <= mod_add(sq_r, d_r, n_r);
          d_r  <= (n_r == size_t'(1)) ? '0 : mod_add(d_r, size_t'(2), n_r);
        end else begin
          // linear and second-hash modes both step by one
          s_r <= mod_add(s_r, size_t'(1), n_r);
        end
      end
      OP_QPOS: begin
        if (quad_r) begin
          s_r <= mod_add(home_r, sq_r, n_r);
        end
      end
      OP_PUT_HOME: begin
        if (!out_busy) begin
          status_r <= STATUS_HOME;
          slot_r   <= home_r[SLOT_W-1:0];
        end
      end
      OP_PUT_MOVED: begin
        if (!out_busy) begin
          status_r <= STATUS_MOVED;
          slot_r   <= s_r[SLOT_W-1:0];
        end
      end
      OP_PUT_FULL: begin
        if (!out_busy) begin
          status_r <= STATUS_FULL;
          slot_r   <= home_r[SLOT_W-1:0];
        end
      end
      default: begin
      end
    endcase
  end

endmodule

FILE: rtl/oah_checker.sv
module oah_checker (
  input logic                     clk,
  input logic                     rst_n,
  input logic                     in_valid,
  input logic                     in_ready,
  input logic                     out_valid,
  input logic                     out_ready,
  input logic [oah_pkg::STATUS_W-1:0] out_status,
  input logic [oah_pkg::SLOT_W-1:0]   out_slot
);
  import oah_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) && $stable(out_slot))
    else $error("stalled result changed or dropped");

  // only defined status codes leave the block
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == STATUS_HOME || out_status == STATUS_MOVED ||
                   out_status == STATUS_FULL))
    else $error("undefined status code");

  // one key at a time: no accept right after an accept
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while a key is in flight");

  // reset drops any pending result
  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result pending after reset");

endmodule

bind open_addressing_hash_insert_core oah_checker u_oah_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_status (out_ch.status),
  .out_slot   (out_ch.slot)
);
